// ===== rtl/csor_pkg.sv =====
package csor_pkg;

	// field widths
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W = 4;
	localparam int unsigned PEND_W = 9;
	localparam int unsigned STEP_W = 6;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_RATIO = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ODO_RATIO = 1'd1;

	// configuration reset values
	localparam logic [BYTE_W-1:0] SPEED_RATIO_RST = 8'd108;
	localparam logic [BYTE_W-1:0] ODO_RATIO_RST = 8'd10;

	// ratio value that turns a correction off
	localparam logic [BYTE_W-1:0] NO_CAL_VALUE = 8'hFF;
	// rolling byte code that is never rescaled
	localparam logic [BYTE_W-1:0] ODO_HOLD_CODE = 8'h02;

	// speed scaling: x / 100 done as (x >> 2) / 25 by reciprocal multiply
	localparam int unsigned SPD_W = 16;
	localparam int unsigned PROD_W = SPD_W + BYTE_W;
	localparam int unsigned PRE_SHIFT = 2;
	localparam int unsigned Y_W = PROD_W - PRE_SHIFT;
	localparam int unsigned SPEED_DIV = 25;
	localparam int unsigned SDIV_W = 5;
	localparam int unsigned RCP_SHIFT = 27;
	localparam int unsigned RCP_W = 23;
	localparam int unsigned RCP_PROD_W = Y_W + RCP_W;
	localparam int unsigned Q0_W = RCP_PROD_W - RCP_SHIFT;
	localparam logic [RCP_W-1:0] RCP_M = RCP_W'((64'd1 << RCP_SHIFT) / SPEED_DIV);
	localparam logic [SDIV_W-1:0] SPEED_DIV_C = SDIV_W'(SPEED_DIV);

	// odometer divider: one quotient bit per cycle
	localparam int unsigned DIV_STEPS = PEND_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	// commands from the controller, at most one per cycle
	typedef struct packed {
		logic load;
		logic mul;
		logic rcp;
		logic cor;
		logic odo;
		logic div_step;
		logic div_end;
		logic fin;
	} csor_cmd_t;

	// status back to the controller
	typedef struct packed {
		logic div_need;
		logic out_hold;
	} csor_sts_t;

endpackage

// ===== rtl/csor_ctrl.sv =====
module csor_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  csor_pkg::csor_sts_t sts,
	output csor_pkg::csor_cmd_t cmd,
	output logic                in_stall
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MUL    = 3'd1;
	localparam logic [2:0] S_RCP    = 3'd2;
	localparam logic [2:0] S_COR    = 3'd3;
	localparam logic [2:0] S_ODO    = 3'd4;
	localparam logic [2:0] S_DIV    = 3'd5;
	localparam logic [2:0] S_DIVEND = 3'd6;
	localparam logic [2:0] S_FIN    = 3'd7;

	localparam logic [csor_pkg::DIV_CNT_W-1:0] CNT_LAST =
		csor_pkg::DIV_CNT_W'(csor_pkg::DIV_STEPS - 1);

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [csor_pkg::DIV_CNT_W-1:0] cnt_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_RCP;
			end
			S_RCP: begin
				cmd.rcp = 1'b1;
				state_d = S_COR;
			end
			S_COR: begin
				cmd.cor = 1'b1;
				state_d = S_ODO;
			end
			S_ODO: begin
				cmd.odo = 1'b1;
				state_d = sts.div_need ? S_DIV : S_FIN;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = S_DIVEND;
				end
			end
			S_DIVEND: begin
				cmd.div_end = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!sts.out_hold) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and divider step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

// ===== rtl/csor_datapath.sv =====
module csor_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  csor_pkg::csor_cmd_t cmd,
	output csor_pkg::csor_sts_t sts,
	input  logic                cfg_wr,
	input  logic [csor_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [csor_pkg::BYTE_W-1:0]    cfg_data,
	input  logic [csor_pkg::BYTE_W-1:0]    id_high,
	input  logic [csor_pkg::BYTE_W-1:0]    id_low,
	input  logic [csor_pkg::LEN_W-1:0]     length,
	input  logic [csor_pkg::BYTE_W-1:0]    byte0_in,
	input  logic [csor_pkg::BYTE_W-1:0]    byte1_in,
	input  logic [csor_pkg::BYTE_W-1:0]    byte2_in,
	input  logic [csor_pkg::BYTE_W-1:0]    byte3_in,
	input  logic [csor_pkg::BYTE_W-1:0]    byte4_in,
	input  logic [csor_pkg::BYTE_W-1:0]    byte5_in,
	input  logic [csor_pkg::BYTE_W-1:0]    byte6_in,
	input  logic                           out_stall,
	output logic                           out_valid,
	output logic [csor_pkg::BYTE_W-1:0]    byte0_out,
	output logic [csor_pkg::BYTE_W-1:0]    byte1_out,
	output logic [csor_pkg::BYTE_W-1:0]    byte2_out,
	output logic [csor_pkg::BYTE_W-1:0]    byte3_out,
	output logic [csor_pkg::BYTE_W-1:0]    byte4_out,
	output logic [csor_pkg::BYTE_W-1:0]    byte5_out,
	output logic [csor_pkg::BYTE_W-1:0]    byte6_out,
	output logic [csor_pkg::BYTE_W-1:0]    byte7_out
);

	localparam int unsigned BW = csor_pkg::BYTE_W;

	// configuration
	logic [BW-1:0] speed_ratio_q;
	logic [BW-1:0] odo_ratio_q;

	// captured frame
	logic [BW-1:0] id_high_q;
	logic [BW-1:0] id_low_q;
	logic [csor_pkg::LEN_W-1:0] len_q;
	logic [BW-1:0] b0_q, b1_q, b2_q, b3_q, b4_q, b5_q, b6_q;

	// speed path
	logic [csor_pkg::PROD_W-1:0] prod_q;
	logic [csor_pkg::Q0_W-1:0] q0_q;
	logic [csor_pkg::SPD_W-1:0] spd_q;
	logic [csor_pkg::Y_W-1:0] spd_y;
	logic [csor_pkg::RCP_PROD_W-1:0] rcp_full;
	logic [csor_pkg::Y_W-1:0] spd_rem;
	logic [csor_pkg::Q0_W-1:0] spd_quo;

	// odometer state
	logic [BW-1:0] last_q;
	logic [BW-1:0] scaled_q;
	logic [csor_pkg::PEND_W-1:0] pend_q;
	logic odo_zero, odo_track, odo_changed;
	logic [BW-1:0] odo_diff;
	logic [csor_pkg::STEP_W-1:0] odo_steps;
	logic [csor_pkg::PEND_W-1:0] pend_sum;

	// divider
	logic [csor_pkg::PEND_W-1:0] div_a_q;
	logic [BW-1:0] div_r_q;
	logic [csor_pkg::PEND_W-1:0] div_shift;
	logic div_ge;
	logic [csor_pkg::PEND_W-1:0] div_next;

	// output
	logic out_valid_q;
	logic [BW-1:0] b4_res;
	logic [csor_pkg::SPD_W-1:0] spd_res;
	logic [BW-1:0] data_res [7];
	logic [2:0] sum_n;
	logic [BW-1:0] csum;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_ratio_q <= csor_pkg::SPEED_RATIO_RST;
			odo_ratio_q <= csor_pkg::ODO_RATIO_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				csor_pkg::REG_SPEED_RATIO: speed_ratio_q <= cfg_data;
				csor_pkg::REG_ODO_RATIO: odo_ratio_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// speed: reciprocal of 25 on the speed product shifted by two
	assign spd_y = prod_q[csor_pkg::PROD_W-1:csor_pkg::PRE_SHIFT];
	assign rcp_full = csor_pkg::RCP_PROD_W'(spd_y) * csor_pkg::RCP_PROD_W'(csor_pkg::RCP_M);
	assign spd_rem = spd_y
		- (csor_pkg::Y_W'(q0_q) * csor_pkg::Y_W'(csor_pkg::SPEED_DIV_C));
	assign spd_quo = q0_q + csor_pkg::Q0_W'(spd_rem >= csor_pkg::Y_W'(csor_pkg::SPEED_DIV));

	// odometer decision and step count
	assign odo_zero = (odo_ratio_q == '0);
	assign odo_track = !odo_zero && (odo_ratio_q != csor_pkg::NO_CAL_VALUE)
		&& (b4_q != csor_pkg::ODO_HOLD_CODE);
	assign odo_changed = (b4_q != last_q);
	assign odo_diff = b4_q - last_q;
	assign odo_steps = odo_diff[BW-1:2];
	assign pend_sum = pend_q + csor_pkg::PEND_W'(odo_steps);
	assign sts.div_need = odo_track && odo_changed && (pend_sum > csor_pkg::PEND_W'(odo_ratio_q));
	assign sts.out_hold = out_valid_q && out_stall;

	// restoring division step
	assign div_shift = {div_r_q, div_a_q[csor_pkg::PEND_W-1]};
	assign div_ge = (div_shift >= csor_pkg::PEND_W'(odo_ratio_q));
	assign div_next = div_ge ? div_shift - csor_pkg::PEND_W'(odo_ratio_q) : div_shift;

	// frame capture and arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_high_q <= id_high;
			id_low_q <= id_low;
			len_q <= length;
			b0_q <= byte0_in;
			b1_q <= byte1_in;
			b2_q <= byte2_in;
			b3_q <= byte3_in;
			b4_q <= byte4_in;
			b5_q <= byte5_in;
			b6_q <= byte6_in;
		end
		if (cmd.mul) begin
			prod_q <= csor_pkg::PROD_W'({b5_q, b6_q}) * csor_pkg::PROD_W'(speed_ratio_q);
		end
		if (cmd.rcp) begin
			q0_q <= rcp_full[csor_pkg::RCP_SHIFT +: csor_pkg::Q0_W];
		end
		if (cmd.cor) begin
			spd_q <= spd_quo[csor_pkg::SPD_W-1:0];
		end
		if (cmd.odo) begin
			div_a_q <= pend_sum;
			div_r_q <= '0;
		end else if (cmd.div_step) begin
			div_a_q <= {div_a_q[csor_pkg::PEND_W-2:0], div_ge};
			div_r_q <= div_next[BW-1:0];
		end
	end

	// odometer state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			scaled_q <= '0;
			pend_q <= '0;
		end else if (cmd.odo && odo_track && odo_changed) begin
			last_q <= b4_q;
			scaled_q <= scaled_q + {odo_steps, 2'b00};
			pend_q <= pend_sum;
		end else if (cmd.div_end) begin
			scaled_q <= scaled_q + {div_a_q[csor_pkg::STEP_W-1:0], 2'b00};
			pend_q <= csor_pkg::PEND_W'(div_r_q);
		end
	end

	// result bytes before the checksum
	assign b4_res = odo_zero ? '0 : (odo_track ? scaled_q : b4_q);
	assign spd_res = (speed_ratio_q == csor_pkg::NO_CAL_VALUE) ? {b5_q, b6_q} : spd_q;
	assign data_res[0] = b0_q;
	assign data_res[1] = b1_q;
	assign data_res[2] = b2_q;
	assign data_res[3] = b3_q;
	assign data_res[4] = b4_res;
	assign data_res[5] = spd_res[csor_pkg::SPD_W-1:BW];
	assign data_res[6] = spd_res[BW-1:0];

	// number of data bytes in the checksum
	always_comb begin
		if (len_q == '0) begin
			sum_n = '0;
		end else if (len_q > csor_pkg::LEN_W'(8)) begin
			sum_n = 3'd7;
		end else begin
			sum_n = 3'(len_q - 1'b1);
		end
	end

	// additive checksum
	always_comb begin
		csum = id_high_q + id_low_q + BW'(len_q);
		for (int i = 0; i < 7; i++) begin
			if (3'(i) < sum_n) begin
				csum = csum + data_res[i];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			byte0_out <= data_res[0];
			byte1_out <= data_res[1];
			byte2_out <= data_res[2];
			byte3_out <= data_res[3];
			byte4_out <= data_res[4];
			byte5_out <= data_res[5];
			byte6_out <= data_res[6];
			byte7_out <= csum;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/can_speed_odometer_rescaler.sv =====
// Rewrites one CAN frame at a time: scales the big-endian speed in bytes 5-6 by
// speed_ratio/100, rescales the rolling odometer byte 4 and puts an additive
// checksum into byte 7. The input stays stalled from acceptance until the result
// is written to the output register; when the pending odometer count has to be
// divided by odometer_ratio, that division is a restoring divider giving one
// quotient bit per cycle. The speed path is a product, a reciprocal multiply
// and a one-step correction, one register each. The result sits in an output
// register, so a new frame can be taken while the last result waits. Write the
// configuration registers only while no frame is in flight.
module can_speed_odometer_rescaler (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [csor_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [csor_pkg::BYTE_W-1:0]           cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [csor_pkg::BYTE_W-1:0]           id_high,
	input  logic [csor_pkg::BYTE_W-1:0]           id_low,
	input  logic [csor_pkg::LEN_W-1:0]            length,
	input  logic [csor_pkg::BYTE_W-1:0]           byte0_in,
	input  logic [csor_pkg::BYTE_W-1:0]           byte1_in,
	input  logic [csor_pkg::BYTE_W-1:0]           byte2_in,
	input  logic [csor_pkg::BYTE_W-1:0]           byte3_in,
	input  logic [csor_pkg::BYTE_W-1:0]           byte4_in,
	input  logic [csor_pkg::BYTE_W-1:0]           byte5_in,
	input  logic [csor_pkg::BYTE_W-1:0]           byte6_in,
	input  logic [csor_pkg::BYTE_W-1:0]           byte7_in,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [csor_pkg::BYTE_W-1:0]           byte0_out,
	output logic [csor_pkg::BYTE_W-1:0]           byte1_out,
	output logic [csor_pkg::BYTE_W-1:0]           byte2_out,
	output logic [csor_pkg::BYTE_W-1:0]           byte3_out,
	output logic [csor_pkg::BYTE_W-1:0]           byte4_out,
	output logic [csor_pkg::BYTE_W-1:0]           byte5_out,
	output logic [csor_pkg::BYTE_W-1:0]           byte6_out,
	output logic [csor_pkg::BYTE_W-1:0]           byte7_out
);

	csor_pkg::csor_cmd_t cmd;
	csor_pkg::csor_sts_t sts;
	logic cfg_wr;

	// registers are always writable; byte 7 of the frame is replaced
	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;

	csor_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	csor_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_wr    (cfg_wr),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.id_high   (id_high),
		.id_low    (id_low),
		.length    (length),
		.byte0_in  (byte0_in),
		.byte1_in  (byte1_in),
		.byte2_in  (byte2_in),
		.byte3_in  (byte3_in),
		.byte4_in  (byte4_in),
		.byte5_in  (byte5_in),
		.byte6_in  (byte6_in),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.byte0_out (byte0_out),
		.byte1_out (byte1_out),
		.byte2_out (byte2_out),
		.byte3_out (byte3_out),
		.byte4_out (byte4_out),
		.byte5_out (byte5_out),
		.byte6_out (byte6_out),
		.byte7_out (byte7_out)
	);

	// an accepted item keeps the input stalled while it is worked on
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after an item was accepted");

	// controller issues at most one command per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	// a new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !(out_valid && out_stall))
		else $error("result register overwritten while stalled");

	// finishing an item presents a result next cycle
	a_fin_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> out_valid)
		else $error("finished item not presented");

endmodule
